@@ hw/rtl/chlp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package chlp_pkg;

    // Key layout: {x[30:0], y[31:0], mode}
    localparam int KEY_W   = 64;
    localparam int X_SHIFT = 33;
    localparam int COORD_W = 32;

    // Multiplicative hash constant
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Operation codes
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_DUP  = 2'd2;
    localparam logic [1:0] STATUS_FULL = 2'd3;

    localparam int HANDLE_OUT_W = 16;
    localparam int COUNT_OUT_W  = 9;

endpackage

`default_nettype wire

@@ hw/rtl/chlp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one table operation per transfer
interface chlp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               layer_mode;
    logic [15:0]        handle_in;

    modport source (
        output valid, func, coord_x, coord_y, layer_mode, handle_in,
        input  ready
    );
    modport sink (
        input  valid, func, coord_x, coord_y, layer_mode, handle_in,
        output ready
    );
endinterface

// Response channel: one result per operation
interface chlp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [8:0]  entry_count;

    modport source (
        output valid, status, handle_out, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, handle_out, entry_count,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/coord_hash_table_linear_probe.sv @@
// Lookup/insert: the request transfer starts the hash, then the probe walks from the home
// slot, one slot per cycle, until an empty slot, a key match or a full wrap; the modulo
// steps come in when CAPACITY is not a power of two. Clear sweeps every slot first; a
// refused insert and the spare code go straight to the result. One operation in flight:
// the next request is taken the cycle after the result is loaded.
// Reset: asynchronous, active low; a clearing pass over every slot follows, ready low.
`timescale 1ns / 1ps
`default_nettype none

module coord_hash_table_linear_probe #(
    parameter int CAPACITY    = 256,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    chlp_req_if.sink     req,
    chlp_rsp_if.source   rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = chlp_pkg::KEY_W;
    localparam int EW = 1 + KW + HANDLE_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_EMIT
    } state_t;

    // Control state
    state_t        state_reg,       state_next;
    logic [1:0]    op_reg,          op_next;
    logic [AW-1:0] idx_reg,         idx_next;
    logic [AW-1:0] probe_cnt_reg,   probe_cnt_next;
    logic [CW-1:0] count_reg,       count_next;
    logic          sweep_reply_reg, sweep_reply_next;
    logic [1:0]    res_status_reg,  res_status_next;
    logic [15:0]   res_handle_reg,  res_handle_next;
    logic          out_valid_reg,   out_valid_next;
    logic [1:0]    out_status_reg,  out_status_next;
    logic [15:0]   out_handle_reg,  out_handle_next;
    logic [8:0]    out_count_reg,   out_count_next;

    // Operation payload
    logic [KW-1:0]          key_reg;
    logic [HANDLE_BITS-1:0] hin_reg;

    logic                   req_xfer;
    logic [KW-1:0]          req_key;
    logic                   table_full;
    logic                   hash_start;
    logic                   hash_done;
    logic [AW-1:0]          hash_home;
    logic [AW-1:0]          idx_inc;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [EW-1:0]          mem_wr_data;
    logic [AW-1:0]          mem_rd_addr;
    logic [EW-1:0]          mem_rd_data;
    logic                   slot_valid;
    logic [KW-1:0]          slot_key;
    logic [HANDLE_BITS-1:0] slot_handle;
    logic                   key_match;
    logic                   out_free;

    assign req_xfer = req.valid && req.ready;
    assign req_key  = {req.coord_x[KW-chlp_pkg::X_SHIFT-1:0], req.coord_y, req.layer_mode};
    assign table_full = (count_reg == CAP_CNT);
    assign hash_start = req_xfer && ((req.func == chlp_pkg::FUNC_LOOKUP) ||
                        ((req.func == chlp_pkg::FUNC_INSERT) && !table_full));

    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : (idx_reg + AW'(1));

    // Unpack the slot under probe
    assign slot_valid  = mem_rd_data[EW-1];
    assign slot_key    = mem_rd_data[EW-2 -: KW];
    assign slot_handle = mem_rd_data[HANDLE_BITS-1:0];
    assign key_match   = (slot_key == key_reg);

    assign out_free = !out_valid_reg || rsp.ready;

    chlp_hash #(
        .CAPACITY (CAPACITY)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req_key),
        .done  (hash_done),
        .home  (hash_home)
    );

    chlp_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        probe_cnt_next   = probe_cnt_reg;
        count_next       = count_reg;
        sweep_reply_next = sweep_reply_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        out_count_next   = out_count_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_reg;
        mem_wr_data      = {1'b1, key_reg, hin_reg};
        mem_rd_addr      = idx_inc;

        // Drop the result once the sink takes it
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg;
                mem_wr_data = '0;
                idx_next    = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    res_status_next = chlp_pkg::STATUS_OK;
                    res_handle_next = '0;
                    state_next      = sweep_reply_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next         = req.func;
                    res_handle_next = '0;
                    case (req.func)
                        chlp_pkg::FUNC_LOOKUP:
                        begin
                            state_next = S_HASH;
                        end
                        chlp_pkg::FUNC_INSERT:
                        begin
                            if (table_full)
                            begin
                                res_status_next = chlp_pkg::STATUS_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        chlp_pkg::FUNC_CLEAR:
                        begin
                            count_next       = '0;
                            idx_next         = '0;
                            sweep_reply_next = 1'b1;
                            state_next       = S_SWEEP;
                        end
                        default:
                        begin
                            res_status_next = chlp_pkg::STATUS_MISS;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                // Issue the read of the home slot
                mem_rd_addr = hash_home;
                if (hash_done)
                begin
                    idx_next       = hash_home;
                    probe_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // Read of the next slot goes out while this one is checked
                if (!slot_valid)
                begin
                    if (op_reg == chlp_pkg::FUNC_INSERT)
                    begin
                        mem_wr_en       = 1'b1;
                        count_next      = count_reg + CW'(1);
                        res_status_next = chlp_pkg::STATUS_OK;
                    end
                    else
                    begin
                        res_status_next = chlp_pkg::STATUS_MISS;
                    end
                    state_next = S_EMIT;
                end
                else if (key_match)
                begin
                    if (op_reg == chlp_pkg::FUNC_INSERT)
                    begin
                        res_status_next = chlp_pkg::STATUS_DUP;
                    end
                    else
                    begin
                        res_status_next = chlp_pkg::STATUS_OK;
                        res_handle_next = 16'(slot_handle);
                    end
                    state_next = S_EMIT;
                end
                else if (probe_cnt_reg == LAST_IDX)
                begin
                    // Wrapped the whole table without a stop
                    res_status_next = (op_reg == chlp_pkg::FUNC_INSERT) ?
                                      chlp_pkg::STATUS_FULL : chlp_pkg::STATUS_MISS;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next       = idx_inc;
                    probe_cnt_next = probe_cnt_reg + AW'(1);
                end
            end
            S_EMIT:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_count_next  = 9'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            op_reg          <= chlp_pkg::FUNC_LOOKUP;
            idx_reg         <= '0;
            probe_cnt_reg   <= '0;
            count_reg       <= '0;
            sweep_reply_reg <= 1'b0;
            res_status_reg  <= chlp_pkg::STATUS_OK;
            res_handle_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= chlp_pkg::STATUS_OK;
            out_handle_reg  <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            idx_reg         <= idx_next;
            probe_cnt_reg   <= probe_cnt_next;
            count_reg       <= count_next;
            sweep_reply_reg <= sweep_reply_next;
            res_status_reg  <= res_status_next;
            res_handle_reg  <= res_handle_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_handle_reg  <= out_handle_next;
            out_count_reg   <= out_count_next;
        end
    end

    // Capture the operation payload on a request transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            key_reg <= req_key;
            hin_reg <= HANDLE_BITS'(req.handle_in);
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.handle_out  = out_handle_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chlp_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Home slot unit: one 32x32 multiplier shared by every multiply step. Two partial
// products give the 64-bit hash product. When the capacity is not a power of
// two, the upper word is folded down by (2^32 mod capacity) until the value
// fits 32 bits. A reciprocal multiply then estimates the quotient, a
// back-multiply forms the remainder, and one compare-subtract corrects it.
module chlp_hash #(
    parameter int CAPACITY = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [chlp_pkg::KEY_W-1:0]  key,
    output logic                             done,
    output logic [$clog2(CAPACITY)-1:0]      home
);

    localparam int          AW      = $clog2(CAPACITY);
    localparam bit          IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [63:0] CAP_64  = 64'(CAPACITY);
    localparam logic [63:0] RCP_64  = 64'h1_0000_0000 / CAP_64;
    localparam logic [63:0] R32_64  = 64'h1_0000_0000 % CAP_64;
    localparam logic [31:0] CAP_V   = CAP_64[31:0];
    localparam logic [31:0] RCP_V   = RCP_64[31:0];
    localparam logic [31:0] R32_V   = R32_64[31:0];
    localparam logic [AW:0] CAP_R   = CAP_64[AW:0];

    typedef enum logic [2:0] {
        H_IDLE,
        H_MUL_LO,
        H_MUL_HI,
        H_FOLD,
        H_RCP,
        H_BACK,
        H_FIX
    } hstate_t;

    hstate_t                    state_reg;
    logic                       done_reg;
    logic [AW-1:0]              home_reg;
    logic [chlp_pkg::KEY_W-1:0] key_reg;
    logic [63:0]                prod_reg;
    logic [31:0]                quot_reg;
    logic [AW:0]                rem_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] prod_sum;
    logic [63:0] fold_sum;
    logic [31:0] rem_diff;
    logic [AW:0] rem_fix;

    // Route the operands of the shared multiplier for the current step
    always_comb
    begin
        mul_a = key_reg[31:0];
        mul_b = chlp_pkg::HASH_MULT;
        case (state_reg)
            H_MUL_HI:
            begin
                mul_a = key_reg[63:32];
            end
            H_FOLD:
            begin
                mul_a = prod_reg[63:32];
                mul_b = R32_V;
            end
            H_RCP:
            begin
                mul_a = prod_reg[31:0];
                mul_b = RCP_V;
            end
            H_BACK:
            begin
                mul_a = quot_reg;
                mul_b = CAP_V;
            end
            default:
            begin
                mul_a = key_reg[31:0];
            end
        endcase
    end

    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign prod_sum = prod_reg + {mul_p[31:0], 32'd0};

    // Fold the upper word back in, form the remainder, correct it once
    assign fold_sum = mul_p + {32'd0, prod_reg[31:0]};
    assign rem_diff = prod_reg[31:0] - mul_p[31:0];
    assign rem_fix  = (rem_reg >= CAP_R) ? (rem_reg - CAP_R) : rem_reg;

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            home_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= H_MUL_LO;
                    end
                end
                H_MUL_LO:
                begin
                    state_reg <= H_MUL_HI;
                end
                H_MUL_HI:
                begin
                    if (IS_POW2)
                    begin
                        home_reg  <= prod_sum[AW-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                    else
                    begin
                        state_reg <= H_FOLD;
                    end
                end
                H_FOLD:
                begin
                    if (fold_sum[63:32] == 32'd0)
                    begin
                        state_reg <= H_RCP;
                    end
                end
                H_RCP:
                begin
                    state_reg <= H_BACK;
                end
                H_BACK:
                begin
                    state_reg <= H_FIX;
                end
                H_FIX:
                begin
                    home_reg  <= rem_fix[AW-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    key_reg <= key;
                end
            end
            H_MUL_LO:
            begin
                prod_reg <= mul_p;
            end
            H_MUL_HI:
            begin
                prod_reg <= prod_sum;
            end
            H_FOLD:
            begin
                prod_reg <= fold_sum;
            end
            H_RCP:
            begin
                quot_reg <= mul_p[63:32];
            end
            H_BACK:
            begin
                rem_reg <= rem_diff[AW:0];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chlp_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Slot store: one write port, one read port with registered read data
module chlp_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 81
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read entry
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
